/* design/sfat_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sfat_pkg;

  localparam int DEFAULT_MAX_FRAMES = 64;

  localparam int OPC_W  = 3;
  localparam int IDX_W  = 6;
  localparam int DUR_W  = 16;
  localparam int TS_W   = 32;
  localparam int FCNT_W = 7;

  localparam logic [OPC_W-1:0] OP_WRITE   = 3'd0;
  localparam logic [OPC_W-1:0] OP_UPDATE  = 3'd1;
  localparam logic [OPC_W-1:0] OP_ENABLE  = 3'd2;
  localparam logic [OPC_W-1:0] OP_PAUSE   = 3'd3;
  localparam logic [OPC_W-1:0] OP_DISABLE = 3'd4;

  // table read address sources
  localparam logic [1:0] RD_PTR  = 2'd0;
  localparam logic [1:0] RD_NEXT = 2'd1;
  localparam logic [1:0] RD_ZERO = 2'd2;
  localparam logic [1:0] RD_SUM  = 2'd3;

  typedef struct packed {
    logic [OPC_W-1:0] opcode;
    logic [IDX_W-1:0] frame_index;
    logic [DUR_W-1:0] frame_duration;
    logic [TS_W-1:0]  now_ms;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] current_frame;
    logic             animating;
    logic [DUR_W-1:0] time_left_ms;
  } out_item_t;

  typedef struct packed {
    logic       take;
    logic       tbl_wr;
    logic       rem_sub;
    logic       def_init;
    logic       ts_load;
    logic       advance;
    logic [1:0] rd_sel;
    logic       rem_load;
    logic       set_run;
    logic       clr_run;
    logic       ptr_clr;
    logic       def_sub;
    logic       sum_clear;
    logic       sum_run;
    logic       div_start;
    logic       div_run;
    logic       div_load;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [OPC_W-1:0] opcode;
    logic             running;
    logic             upd_fit;
    logic             def_neg;
    logic             sum_done;
    logic             div_done;
    logic             out_free;
  } status_t;

endpackage

`default_nettype wire

/* design/sfat_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module sfat_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire sfat_pkg::status_t status,
  output sfat_pkg::cmd_t        cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_FIRST = 3'd3;
  localparam logic [2:0] S_SUM   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_STEP  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = sfat_pkg::RD_PTR;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (status.opcode)
          sfat_pkg::OP_WRITE: begin
            cmd.tbl_wr = 1'b1;
            state_next = S_DONE;
          end
          sfat_pkg::OP_UPDATE: begin
            if (!status.running) begin
              state_next = S_DONE;
            end else if (status.upd_fit) begin
              cmd.rem_sub = 1'b1;
              cmd.ts_load = 1'b1;
              state_next  = S_DONE;
            end else begin
              cmd.def_init = 1'b1;
              cmd.ts_load  = 1'b1;
              cmd.advance  = 1'b1;
              cmd.rd_sel   = sfat_pkg::RD_NEXT;
              state_next   = S_FIRST;
            end
          end
          sfat_pkg::OP_ENABLE: begin
            cmd.rd_sel = sfat_pkg::RD_PTR;
            state_next = S_LOAD;
          end
          sfat_pkg::OP_PAUSE: begin
            cmd.clr_run = 1'b1;
            state_next  = S_DONE;
          end
          sfat_pkg::OP_DISABLE: begin
            cmd.clr_run = 1'b1;
            cmd.ptr_clr = 1'b1;
            cmd.rd_sel  = sfat_pkg::RD_ZERO;
            state_next  = S_LOAD;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_LOAD: begin
        cmd.rem_load = 1'b1;
        if (status.opcode == sfat_pkg::OP_ENABLE) begin
          cmd.set_run = 1'b1;
          cmd.ts_load = 1'b1;
        end
        state_next = S_DONE;
      end
      S_FIRST: begin
        cmd.def_sub = 1'b1;
        if (status.def_neg) begin
          state_next = S_DONE;
        end else begin
          cmd.sum_clear = 1'b1;
          state_next    = S_SUM;
        end
      end
      S_SUM: begin
        cmd.rd_sel = sfat_pkg::RD_SUM;
        if (status.sum_done) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          cmd.sum_run = 1'b1;
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          // remainder becomes the deficit; at least one more step follows
          cmd.div_load = 1'b1;
          cmd.advance  = 1'b1;
          cmd.rd_sel   = sfat_pkg::RD_NEXT;
          state_next   = S_STEP;
        end else begin
          cmd.div_run = 1'b1;
        end
      end
      S_STEP: begin
        cmd.def_sub = 1'b1;
        if (status.def_neg) begin
          state_next = S_DONE;
        end else begin
          cmd.advance = 1'b1;
          cmd.rd_sel  = sfat_pkg::RD_NEXT;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* design/sfat_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module sfat_datapath #(
  parameter int MAX_FRAMES = sfat_pkg::DEFAULT_MAX_FRAMES
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire sfat_pkg::in_item_t            in_data,
  input  wire logic                          cfg_wr_en,
  input  wire logic [sfat_pkg::FCNT_W-1:0]   cfg_wr_data,
  input  wire sfat_pkg::cmd_t                cmd,
  output sfat_pkg::status_t                  status,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output sfat_pkg::out_item_t                out_data
);

  localparam int PTR_W  = $clog2(MAX_FRAMES);
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int SUM_W  = sfat_pkg::DUR_W + CNT_W;
  localparam int DUR_W  = sfat_pkg::DUR_W;
  localparam int TS_W   = sfat_pkg::TS_W;
  localparam int DCNT_W = $clog2(TS_W + 1);

  sfat_pkg::in_item_t          item;
  logic [sfat_pkg::FCNT_W-1:0] frame_count;

  logic [DUR_W-1:0] dur_mem [MAX_FRAMES];
  logic [DUR_W-1:0] rd_q;
  logic [PTR_W-1:0] rd_addr;

  logic [PTR_W-1:0] ptr;
  logic [DUR_W-1:0] rem;
  logic [TS_W-1:0]  last_ts;
  logic             running;
  logic [TS_W-1:0]  deficit;

  logic [CNT_W-1:0] sum_idx;
  logic             sum_pend;
  logic [SUM_W-1:0] cycle_sum;

  logic [TS_W-1:0]   div_q;
  logic [SUM_W-1:0]  div_r;
  logic [DCNT_W-1:0] div_cnt;

  logic [CNT_W-1:0] n_frames;
  logic [PTR_W-1:0] ptr_next;
  logic [DUR_W-1:0] ft;
  logic [TS_W-1:0]  elapsed;
  logic [TS_W:0]    upd_diff;
  logic [TS_W:0]    def_diff;
  logic [SUM_W:0]   div_try;
  logic [SUM_W:0]   div_sub;

  // frames in use, clamped to 1..MAX_FRAMES
  always_comb begin
    if (frame_count == '0) begin
      n_frames = CNT_W'(1);
    end else if (int'(frame_count) > MAX_FRAMES) begin
      n_frames = CNT_W'(MAX_FRAMES);
    end else begin
      n_frames = CNT_W'(frame_count);
    end
  end

  assign ptr_next = ((CNT_W'(ptr) + CNT_W'(1)) >= n_frames) ? '0 : ptr + PTR_W'(1);

  // stored zero counts as one
  assign ft = (rd_q == '0) ? DUR_W'(1) : rd_q;

  assign elapsed  = item.now_ms - last_ts;
  assign upd_diff = {{(TS_W + 1 - DUR_W){1'b0}}, rem} - {1'b0, elapsed};
  assign def_diff = {1'b0, deficit} - {{(TS_W + 1 - DUR_W){1'b0}}, ft};

  assign div_try = {div_r, div_q[TS_W-1]};
  assign div_sub = div_try - {1'b0, cycle_sum};

  always_comb begin
    case (cmd.rd_sel)
      sfat_pkg::RD_PTR:  rd_addr = ptr;
      sfat_pkg::RD_NEXT: rd_addr = ptr_next;
      sfat_pkg::RD_ZERO: rd_addr = '0;
      sfat_pkg::RD_SUM:  rd_addr = sum_idx[PTR_W-1:0];
      default:           rd_addr = ptr;
    endcase
  end

  always_comb begin
    status          = '0;
    status.opcode   = item.opcode;
    status.running  = running;
    status.upd_fit  = !upd_diff[TS_W] && (upd_diff != '0);
    status.def_neg  = def_diff[TS_W];
    status.sum_done = (sum_idx >= n_frames) && !sum_pend;
    status.div_done = (div_cnt == DCNT_W'(TS_W));
    status.out_free = !out_valid || !out_stall;
  end

  // duration table
  always_ff @(posedge clk) begin
    if (cmd.tbl_wr && (int'(item.frame_index) < MAX_FRAMES)) begin
      dur_mem[PTR_W'(item.frame_index)] <= item.frame_duration;
    end
    rd_q <= dur_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= sfat_pkg::FCNT_W'(1);
    end else if (cfg_wr_en) begin
      frame_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr     <= '0;
      rem     <= '0;
      last_ts <= '0;
      running <= 1'b0;
    end else begin
      if (cmd.ptr_clr) begin
        ptr <= '0;
      end else if (cmd.advance) begin
        ptr <= ptr_next;
      end
      if (cmd.rem_sub) begin
        rem <= upd_diff[DUR_W-1:0];
      end else if (cmd.rem_load) begin
        rem <= ft;
      end else if (cmd.def_sub && def_diff[TS_W]) begin
        rem <= ft - deficit[DUR_W-1:0];
      end
      if (cmd.ts_load) begin
        last_ts <= item.now_ms;
      end
      if (cmd.clr_run) begin
        running <= 1'b0;
      end else if (cmd.set_run) begin
        running <= 1'b1;
      end
    end
  end

  // deficit: time overdue past the end of the current frame
  always_ff @(posedge clk) begin
    if (cmd.def_init) begin
      deficit <= elapsed - {{(TS_W - DUR_W){1'b0}}, rem};
    end else if (cmd.def_sub && !def_diff[TS_W]) begin
      deficit <= def_diff[TS_W-1:0];
    end else if (cmd.div_load) begin
      deficit <= TS_W'(div_r);
    end
  end

  // sum of all frame durations, one table read per cycle
  always_ff @(posedge clk) begin
    if (cmd.sum_clear) begin
      sum_idx   <= '0;
      sum_pend  <= 1'b0;
      cycle_sum <= '0;
    end else if (cmd.sum_run) begin
      if (sum_idx < n_frames) begin
        sum_idx  <= sum_idx + CNT_W'(1);
        sum_pend <= 1'b1;
      end else begin
        sum_pend <= 1'b0;
      end
      if (sum_pend) begin
        cycle_sum <= cycle_sum + SUM_W'(ft);
      end
    end
  end

  // restoring remainder: deficit mod cycle_sum, one bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_q   <= deficit;
      div_r   <= '0;
      div_cnt <= '0;
    end else if (cmd.div_run) begin
      div_q   <= {div_q[TS_W-2:0], 1'b0};
      div_cnt <= div_cnt + DCNT_W'(1);
      if (!div_sub[SUM_W]) begin
        div_r <= div_sub[SUM_W-1:0];
      end else begin
        div_r <= div_try[SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.current_frame <= sfat_pkg::IDX_W'(ptr);
      out_data.animating     <= running;
      out_data.time_left_ms  <= rem;
    end
  end

endmodule

`default_nettype wire

/* design/sprite_frame_animation_timer.sv */
// Sprite frame animation timer.
// Input channel in_valid/in_stall carries one item per operation: write a
// frame duration, update at a timestamp, enable, pause or disable. Every
// item produces exactly one result on out_valid/out_stall: current frame,
// running flag and milliseconds left in the frame.
// The user must write frame_count through cfg_wr_en/cfg_wr_data only
// while idle; the block itself does not enforce this. Write, pause,
// unknown codes and an update that stays in the current frame go from
// the execute state straight to the output; enable and disable pass through
// the load state, an update that moves on by one frame through the first-step
// state. An update that runs past the next frame sums the table (one table
// read per cycle), takes the overdue time modulo that sum (one bit per cycle)
// and then steps one frame per cycle. One item is in work at a time; the next
// is accepted the cycle after the result enters the output register.
// A result held by out_stall stays put; a finished item waits for the
// register to free. Reset clears frame, time, timestamp, running and sets
// frame_count to 1; the duration table holds nothing until written.
`timescale 1ns / 1ps
`default_nettype none

module sprite_frame_animation_timer #(
  parameter int MAX_FRAMES = sfat_pkg::DEFAULT_MAX_FRAMES
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire sfat_pkg::in_item_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output sfat_pkg::out_item_t              out_data,
  input  wire logic                        cfg_wr_en,
  input  wire logic [sfat_pkg::FCNT_W-1:0] cfg_wr_data
);

  sfat_pkg::cmd_t    cmd;
  sfat_pkg::status_t status;

  sfat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sfat_datapath #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

/* dv/sprite_frame_animation_timer_test.sv */
`timescale 1ns / 1ps

module sprite_frame_animation_timer_test;

  localparam int WATCHDOG_CYCLES = 3000;
  localparam int DRAIN_CYCLES    = 200;
  localparam int TABLE_DEPTH     = 64;
  localparam int TBL_AW          = $clog2(TABLE_DEPTH);
  localparam int PHASE_ITEMS     = 68;

  localparam int OPC_W  = sfat_pkg::OPC_W;
  localparam int IDX_W  = sfat_pkg::IDX_W;
  localparam int DUR_W  = sfat_pkg::DUR_W;
  localparam int TS_W   = sfat_pkg::TS_W;
  localparam int FCNT_W = sfat_pkg::FCNT_W;

  localparam logic [OPC_W-1:0] OP_RSVD5 = 3'd5;
  localparam logic [OPC_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OPC_W-1:0] OP_RSVD7 = 3'd7;

  typedef struct {
    bit                  is_cfg;
    logic [FCNT_W-1:0]   fcnt;
    sfat_pkg::in_item_t  it;
    bit                  typed;
    sfat_pkg::out_item_t want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  sfat_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  sfat_pkg::out_item_t out_data;
  logic                cfg_wr_en = 1'b0;
  logic [FCNT_W-1:0]   cfg_wr_data = '0;

  // timer state as the block should hold it
  logic [DUR_W-1:0]  dur_mem [TABLE_DEPTH];
  int                shown_frame;
  longint            left_ms;
  logic [TS_W-1:0]   last_ms;
  bit                running;
  logic [FCNT_W-1:0] frame_count_reg;

  sfat_pkg::out_item_t display_q [$];
  int                  mismatches = 0;
  int                  idle_cycles = 0;
  bit                  quiet = 1'b0;
  dir_row_t            rows [$];

  always #5 clk = ~clk;

  sprite_frame_animation_timer i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  function automatic int frames_in_use();
    int n;
    n = int'(frame_count_reg);
    if (n == 0) n = 1;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    return n;
  endfunction

  // a stored zero counts as 1 ms
  function automatic longint frame_ms(int f);
    longint d;
    d = longint'(dur_mem[f[TBL_AW-1:0]]);
    if (d == 0) d = 1;
    return d;
  endfunction

  function automatic longint loop_ms();
    longint sum;
    sum = 0;
    for (int i = 0; i < frames_in_use(); i++) sum += frame_ms(i);
    return sum;
  endfunction

  function automatic void step_frame(int n);
    shown_frame++;
    if (shown_frame >= n) shown_frame = 0;
    left_ms += frame_ms(shown_frame);
  endfunction

  function automatic sfat_pkg::out_item_t next_display(sfat_pkg::in_item_t it);
    int n;
    longint cyc;
    longint elapsed;
    logic [TS_W-1:0] delta;
    sfat_pkg::out_item_t r;
    case (it.opcode)
      sfat_pkg::OP_WRITE: dur_mem[it.frame_index] = it.frame_duration;
      sfat_pkg::OP_UPDATE: if (running) begin
        n = frames_in_use();
        delta = it.now_ms - last_ms;
        elapsed = longint'(delta);
        left_ms -= elapsed;
        if (left_ms <= 0) begin
          step_frame(n);
          if (left_ms <= 0) begin
            // skip whole passes through the table at once
            cyc = loop_ms();
            left_ms += ((-left_ms) / cyc) * cyc;
            while (left_ms <= 0) step_frame(n);
          end
        end
        last_ms = it.now_ms;
      end
      sfat_pkg::OP_ENABLE: begin
        left_ms = frame_ms(shown_frame);
        last_ms = it.now_ms;
        running = 1'b1;
      end
      sfat_pkg::OP_PAUSE: running = 1'b0;
      sfat_pkg::OP_DISABLE: begin
        running = 1'b0;
        shown_frame = 0;
        left_ms = frame_ms(0);
      end
      default: ;
    endcase
    r.current_frame = shown_frame[IDX_W-1:0];
    r.animating = running;
    r.time_left_ms = left_ms[DUR_W-1:0];
    return r;
  endfunction

  function automatic logic [DUR_W-1:0] pick_ms();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 7) return DUR_W'($urandom_range(1, 20));
    return DUR_W'($urandom);
  endfunction

  function automatic sfat_pkg::in_item_t rand_item();
    sfat_pkg::in_item_t it;
    int r;
    longint span;
    logic [TS_W-1:0] delta;
    it.opcode = sfat_pkg::OP_UPDATE;
    it.frame_index = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
    it.frame_duration = DUR_W'($urandom);
    it.now_ms = $urandom;
    r = $urandom_range(0, 99);
    // mostly keep the timer running so updates have work to do
    if (!running && r >= 23 && $urandom_range(0, 9) < 7) r = 8;
    if (r < 6) begin
      it.opcode = sfat_pkg::OP_WRITE;
      it.frame_duration = pick_ms();
    end else if (r < 12) begin
      it.opcode = sfat_pkg::OP_ENABLE;
      if ($urandom_range(0, 1)) it.now_ms = last_ms + $urandom_range(0, 1000);
    end else if (r < 16) begin
      it.opcode = sfat_pkg::OP_PAUSE;
    end else if (r < 20) begin
      it.opcode = sfat_pkg::OP_DISABLE;
    end else if (r < 23) begin
      it.opcode = OPC_W'($urandom_range(OP_RSVD5, OP_RSVD7));
    end else begin
      r = $urandom_range(0, 99);
      span = loop_ms();
      if (r < 10) delta = '0;
      else if (r < 20) delta = left_ms[31:0];
      else if (r < 50) delta = $urandom_range(1, (left_ms > 0) ? left_ms[31:0] : 1);
      else if (r < 80) delta = $urandom_range(1, span[31:0] * 3);
      else if (r < 90) delta = $urandom;
      else delta = 32'hFFFF_FFFF - $urandom_range(0, 99);
      it.now_ms = last_ms + delta;
    end
    return it;
  endfunction

  function automatic dir_row_t item_row(logic [OPC_W-1:0] op, logic [IDX_W-1:0] idx,
                                        logic [DUR_W-1:0] dur, logic [TS_W-1:0] now,
                                        bit typed, logic [IDX_W-1:0] fr, bit an,
                                        logic [DUR_W-1:0] left);
    dir_row_t r;
    r.is_cfg = 1'b0;
    r.fcnt = '0;
    r.it = {op, idx, dur, now};
    r.typed = typed;
    r.want = {fr, an, left};
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [FCNT_W-1:0] v);
    dir_row_t r;
    r.is_cfg = 1'b1;
    r.fcnt = v;
    r.it = '0;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("error at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(sfat_pkg::in_item_t it, bit typed, sfat_pkg::out_item_t want);
    int gap;
    sfat_pkg::out_item_t guess;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    guess = next_display(it);
    display_q.push_back(typed ? want : guess);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (display_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_frame_count(logic [FCNT_W-1:0] v);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    frame_count_reg = v;
  endtask

  // result side
  initial begin
    sfat_pkg::out_item_t want;
    int w;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      w = quiet ? 0 : $urandom_range(0, 11);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      if (display_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: frame %0d run %0d left %0d",
                                  out_data.current_frame, out_data.animating,
                                  out_data.time_left_ms));
      end else begin
        want = display_q.pop_front();
        if (out_data.current_frame !== want.current_frame)
          report_mismatch($sformatf("current_frame %0d, expected %0d",
                                    out_data.current_frame, want.current_frame));
        if (out_data.animating !== want.animating)
          report_mismatch($sformatf("animating %0d, expected %0d",
                                    out_data.animating, want.animating));
        if (out_data.time_left_ms !== want.time_left_ms)
          report_mismatch($sformatf("time_left_ms %0d, expected %0d",
                                    out_data.time_left_ms, want.time_left_ms));
      end
      @(negedge clk);
    end
  end

  // watchdog: no item moving on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [FCNT_W-1:0] fc_list [8];
    sfat_pkg::in_item_t it;
    shown_frame = 0;
    left_ms = 0;
    last_ms = '0;
    running = 1'b0;
    frame_count_reg = 7'd1;

    // frame count 1 after reset; entry 0 holds zero, used as 1 ms
    rows.push_back(item_row(sfat_pkg::OP_PAUSE,   6'd0,  16'h0000, 32'h0000_0000,
                            1'b1, 6'd0, 1'b0, 16'd0));
    rows.push_back(item_row(OP_RSVD7,             6'd63, 16'hFFFF, 32'hFFFF_FFFF,
                            1'b1, 6'd0, 1'b0, 16'd0));
    rows.push_back(item_row(sfat_pkg::OP_WRITE,   6'd0,  16'h0000, 32'h0000_0000,
                            1'b1, 6'd0, 1'b0, 16'd0));
    rows.push_back(item_row(sfat_pkg::OP_ENABLE,  6'd0,  16'h0000, 32'd100,
                            1'b1, 6'd0, 1'b1, 16'd1));
    rows.push_back(item_row(sfat_pkg::OP_UPDATE,  6'd0,  16'h0000, 32'd100,
                            1'b0, 6'd0, 1'b0, 16'd0));
    rows.push_back(item_row(sfat_pkg::OP_WRITE,   6'd0,  16'hFFFF, 32'h0000_0000,
                            1'b1, 6'd0, 1'b1, 16'd1));
    rows.push_back(item_row(sfat_pkg::OP_UPDATE,  6'd0,  16'h0000, 32'd101,
                            1'b0, 6'd0, 1'b0, 16'd0));
    // elapsed of 2^32 - 1
    rows.push_back(item_row(sfat_pkg::OP_UPDATE,  6'd0,  16'h0000, 32'd100,
                            1'b0, 6'd0, 1'b0, 16'd0));
    rows.push_back(item_row(sfat_pkg::OP_PAUSE,   6'd0,  16'h0000, 32'h0000_0000,
                            1'b0, 6'd0, 1'b0, 16'd0));
    // stopped: update leaves timestamp alone
    rows.push_back(item_row(sfat_pkg::OP_UPDATE,  6'd0,  16'h0000, 32'd5,
                            1'b0, 6'd0, 1'b0, 16'd0));
    rows.push_back(item_row(sfat_pkg::OP_WRITE,   6'd1,  16'd3,    32'h0000_0000,
                            1'b0, 6'd0, 1'b0, 16'd0));
    rows.push_back(item_row(sfat_pkg::OP_WRITE,   6'd2,  16'd1,    32'h0000_0000,
                            1'b0, 6'd0, 1'b0, 16'd0));
    rows.push_back(item_row(sfat_pkg::OP_WRITE,   6'd3,  16'd2,    32'h0000_0000,
                            1'b0, 6'd0, 1'b0, 16'd0));
    rows.push_back(item_row(sfat_pkg::OP_WRITE,   6'd63, 16'h8000, 32'h0000_0000,
                            1'b0, 6'd0, 1'b0, 16'd0));
    rows.push_back(cfg_row(7'd3));
    rows.push_back(item_row(sfat_pkg::OP_DISABLE, 6'd0,  16'h0000, 32'h0000_0000,
                            1'b1, 6'd0, 1'b0, 16'hFFFF));
    rows.push_back(item_row(sfat_pkg::OP_WRITE,   6'd0,  16'd4,    32'h0000_0000,
                            1'b0, 6'd0, 1'b0, 16'd0));
    rows.push_back(item_row(sfat_pkg::OP_ENABLE,  6'd0,  16'h0000, 32'hFFFF_FFF0,
                            1'b1, 6'd0, 1'b1, 16'd4));
    rows.push_back(item_row(sfat_pkg::OP_UPDATE,  6'd0,  16'h0000, 32'hFFFF_FFF4,
                            1'b0, 6'd0, 1'b0, 16'd0));
    // timestamp wraps through zero
    rows.push_back(item_row(sfat_pkg::OP_UPDATE,  6'd0,  16'h0000, 32'h0000_0002,
                            1'b0, 6'd0, 1'b0, 16'd0));
    rows.push_back(item_row(sfat_pkg::OP_UPDATE,  6'd0,  16'h0000, 32'h0000_1000,
                            1'b0, 6'd0, 1'b0, 16'd0));
    // pointer may now sit past the frame count
    rows.push_back(cfg_row(7'd1));
    rows.push_back(item_row(sfat_pkg::OP_UPDATE,  6'd0,  16'h0000, 32'h0000_1100,
                            1'b0, 6'd0, 1'b0, 16'd0));
    rows.push_back(item_row(OP_RSVD5,             6'd21, 16'h5555, 32'hAAAA_AAAA,
                            1'b0, 6'd0, 1'b0, 16'd0));
    rows.push_back(item_row(OP_RSVD6,             6'd42, 16'hAAAA, 32'h5555_5555,
                            1'b0, 6'd0, 1'b0, 16'd0));
    rows.push_back(cfg_row(7'd0));
    rows.push_back(item_row(sfat_pkg::OP_ENABLE,  6'd0,  16'h0000, 32'd7,
                            1'b0, 6'd0, 1'b0, 16'd0));
    rows.push_back(item_row(sfat_pkg::OP_UPDATE,  6'd0,  16'h0000, 32'd9,
                            1'b0, 6'd0, 1'b0, 16'd0));

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].is_cfg) set_frame_count(rows[i].fcnt);
      else send_item(rows[i].it, rows[i].typed, rows[i].want);
    end

    // fill the whole table before anything may read past entry 3
    for (int f = 0; f < TABLE_DEPTH; f++) begin
      it = {sfat_pkg::OP_WRITE, f[IDX_W-1:0], pick_ms(), TS_W'(f)};
      send_item(it, 1'b0, '0);
    end

    fc_list = '{7'd64, 7'd2, 7'd127, 7'd0, 7'd33, 7'd65, 7'd1, 7'd17};
    fc_list[4] = FCNT_W'($urandom_range(1, 64));
    fc_list[7] = FCNT_W'($urandom_range(1, 64));
    for (int p = 0; p < 8; p++) begin
      set_frame_count(fc_list[p]);
      quiet = (p == 2) || ($urandom_range(0, 4) == 0);
      for (int k = 0; k < PHASE_ITEMS; k++) send_item(rand_item(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (display_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
design/sfat_pkg.sv
design/sfat_ctrl.sv
design/sfat_datapath.sv
design/sprite_frame_animation_timer.sv
dv/sprite_frame_animation_timer_test.sv
